>>> rtl/assert_macros.svh
// Assertion shorthands for the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MVSF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication, disabled while reset is held.
`define MVSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

>>> rtl/mvsf_pkg.sv
package mvsf_pkg;

    // Sizes
    localparam int unsigned SLOT_COUNT_DEF = 8192;
    localparam int unsigned SLOT_W         = 13;
    localparam int unsigned VAL_W          = 32;
    localparam int unsigned CNT_W          = 14;
    localparam int unsigned EPOCH_W        = 8;
    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 32;

    // Highest count reachable: every addressable slot marked
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1 << SLOT_W);

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_COMPARE = 2'd1,
        OP_QUERY   = 2'd2,
        OP_STOP    = 2'd3
    } t_opcode;

    typedef enum logic [3:0] {
        CMP_EXACT      = 4'd0,
        CMP_LT         = 4'd1,
        CMP_LE         = 4'd2,
        CMP_GT         = 4'd3,
        CMP_GE         = 4'd4,
        CMP_EQ         = 4'd5,
        CMP_NE         = 4'd6,
        CMP_PREV_PLUS  = 4'd7,
        CMP_PREV_MINUS = 4'd8
    } t_cmp_mode;

    typedef enum logic [1:0] {
        WSEL_8  = 2'd0,
        WSEL_16 = 2'd1,
        WSEL_32 = 2'd2
    } t_wsel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 2'd0,
        CFG_OPERAND = 2'd1,
        CFG_WIDTH   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_opcode             opcode;
        logic [SLOT_W-1:0]   slot_index;
        logic [VAL_W-1:0]    current_value;
    } t_in_req;

    typedef struct packed {
        logic                session_open;
        logic [SLOT_W-1:0]   slot_echo;
        logic                still_candidate;
        logic [VAL_W-1:0]    stored_value;
        logic [CNT_W-1:0]    candidate_count;
    } t_out_rsp;

    // One entry of the mark memory: a mark counts only in its own epoch
    typedef struct packed {
        logic                mark;
        logic [EPOCH_W-1:0]  epoch;
    } t_mark_ent;

    function automatic logic [VAL_W-1:0] width_mask(input logic [1:0] wsel);
        logic [VAL_W-1:0] m;
        unique case (wsel)
            WSEL_8:  m = VAL_W'(32'h0000_00FF);
            WSEL_16: m = VAL_W'(32'h0000_FFFF);
            default: m = '1;
        endcase
        return m;
    endfunction

    // cur, prev and op are already masked
    function automatic logic check_value(
        input logic [3:0]       mode,
        input logic [VAL_W-1:0] cur,
        input logic [VAL_W-1:0] prev,
        input logic [VAL_W-1:0] op,
        input logic [VAL_W-1:0] mask
    );
        logic             ok;
        logic [VAL_W-1:0] sum;
        logic [VAL_W-1:0] dif;
        sum = (prev + op) & mask;
        dif = (prev - op) & mask;
        unique case (mode)
            CMP_EXACT:      ok = (cur == op);
            CMP_LT:         ok = (cur < prev);
            CMP_LE:         ok = (cur <= prev);
            CMP_GT:         ok = (cur > prev);
            CMP_GE:         ok = (cur >= prev);
            CMP_EQ:         ok = (cur == prev);
            CMP_NE:         ok = (cur != prev);
            CMP_PREV_PLUS:  ok = (cur == sum);
            CMP_PREV_MINUS: ok = (cur == dif);
            default:        ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

>>> rtl/memory_value_search_filter.sv
// Memory value search filter. Requests (start, compare, query, stop) enter one per cycle
// and each gives one response. The slot's value and mark memories are read at acceptance.
// The write-back stage then resolves the request, writes it back and loads the response
// register, which offers the response. A request to the slot just written takes the new
// data from a forwarding register. Sustained rate is one request per cycle while the
// response side keeps taking. Marks carry an epoch tag, so a stop clears all marks at once.
// After reset a clearing pass sweeps every entry of the mark memory and no request is
// taken meanwhile. Every 2**EPOCH_W-th stop does the same: no request is taken beside
// that stop, and the same pass follows it.
// Configuration registers may be written at any time the block is idle.
module memory_value_search_filter #(
    parameter int unsigned SLOT_COUNT = mvsf_pkg::SLOT_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mvsf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mvsf_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  mvsf_pkg::t_in_req                 i_in_req,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output mvsf_pkg::t_out_rsp                o_out_rsp
);

    localparam int unsigned ADDR_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned VAL_W   = mvsf_pkg::VAL_W;
    localparam int unsigned CNT_W   = mvsf_pkg::CNT_W;
    localparam int unsigned EPOCH_W = mvsf_pkg::EPOCH_W;

    // Configuration
    logic [3:0]       r_cmp_mode;
    logic [VAL_W-1:0] r_operand;
    logic [1:0]       r_wsel;

    // Session state
    logic               r_sess;
    logic [CNT_W-1:0]   r_cnt;
    logic [EPOCH_W-1:0] r_epoch;
    logic               r_clearing;
    logic [ADDR_W-1:0]  r_clr_addr;

    // Memories and their read registers
    logic [VAL_W-1:0]    r_val_mem  [SLOT_COUNT];
    mvsf_pkg::t_mark_ent r_mark_mem [SLOT_COUNT];
    logic [VAL_W-1:0]    r_rd_val;
    mvsf_pkg::t_mark_ent r_rd_ent;

    // Write-back stage
    logic              r_s1_vld;
    mvsf_pkg::t_in_req r_s1_req;
    logic              r_fw_hit;
    logic [VAL_W-1:0]  r_fw_val;
    logic              r_fw_mark;

    // Output register
    logic               r_out_vld;
    mvsf_pkg::t_out_rsp r_out;

    logic               in_acc;
    logic               s1_go;
    logic [ADDR_W-1:0]  in_addr;
    logic [ADDR_W-1:0]  s1_addr;
    logic               s1_inr;
    logic [VAL_W-1:0]   mask;
    logic [VAL_W-1:0]   cur;
    logic [VAL_W-1:0]   op;
    logic [VAL_W-1:0]   prev_raw;
    logic               mark_cur;
    logic               mark_new;
    logic [VAL_W-1:0]   val_new;
    logic               wr;
    logic               n_sess;
    logic [CNT_W-1:0]   n_cnt;
    logic [EPOCH_W-1:0] n_epoch;
    logic               clr_start;
    mvsf_pkg::t_out_rsp rsp;

    // Handshake; nothing enters beside a stop that starts a clearing pass
    assign s1_go      = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_clearing && (!r_s1_vld || (s1_go && !clr_start));
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_addr    = ADDR_W'(i_in_req.slot_index);
    assign s1_addr    = ADDR_W'(r_s1_req.slot_index);
    assign s1_inr     = 32'(r_s1_req.slot_index) < 32'(SLOT_COUNT);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_mode <= mvsf_pkg::CMP_EXACT;
            r_operand  <= '0;
            r_wsel     <= mvsf_pkg::WSEL_32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                mvsf_pkg::CFG_MODE:    r_cmp_mode <= i_cfg_wdata[3:0];
                mvsf_pkg::CFG_OPERAND: r_operand  <= i_cfg_wdata[VAL_W-1:0];
                mvsf_pkg::CFG_WIDTH:   r_wsel     <= i_cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Modify step: read data (or forwarded data) against the request
    always_comb begin
        mask      = mvsf_pkg::width_mask(r_wsel);
        cur       = r_s1_req.current_value & mask;
        op        = r_operand & mask;
        prev_raw  = r_fw_hit ? r_fw_val : r_rd_val;
        mark_cur  = r_fw_hit ? r_fw_mark : (r_rd_ent.mark && (r_rd_ent.epoch == r_epoch));
        mark_new  = mark_cur;
        val_new   = prev_raw;
        wr        = 1'b0;
        n_sess    = r_sess;
        n_cnt     = r_cnt;
        n_epoch   = r_epoch;
        clr_start = 1'b0;
        unique case (r_s1_req.opcode)
            mvsf_pkg::OP_START: begin
                n_sess = 1'b1;
                if (s1_inr) begin
                    wr       = 1'b1;
                    val_new  = cur;
                    mark_new = 1'b1;
                    if (!mark_cur) begin
                        n_cnt = CNT_W'(r_cnt + 1'b1);
                    end
                end
            end
            mvsf_pkg::OP_COMPARE: begin
                if (r_sess && s1_inr) begin
                    wr      = 1'b1;
                    val_new = cur;
                    if (mark_cur &&
                        !mvsf_pkg::check_value(r_cmp_mode, cur, prev_raw & mask, op, mask)) begin
                        mark_new = 1'b0;
                        if (r_cnt != '0) begin
                            n_cnt = CNT_W'(r_cnt - 1'b1);
                        end
                    end
                end
            end
            mvsf_pkg::OP_QUERY: ;
            mvsf_pkg::OP_STOP: begin
                n_sess    = 1'b0;
                n_cnt     = '0;
                n_epoch   = EPOCH_W'(r_epoch + 1'b1);
                clr_start = (n_epoch == '0);
            end
            default: ;
        endcase

        rsp.session_open    = n_sess;
        rsp.slot_echo       = r_s1_req.slot_index;
        rsp.still_candidate = (n_sess && s1_inr) ? mark_new : 1'b0;
        rsp.stored_value    = (n_sess && s1_inr) ? val_new : '0;
        rsp.candidate_count = n_sess ? n_cnt : '0;
    end

    // Value memory: read at acceptance, write back from the modify step
    always_ff @(posedge i_clk) begin
        if (s1_go && wr) begin
            r_val_mem[s1_addr] <= val_new;
        end
        if (in_acc) begin
            r_rd_val <= r_val_mem[in_addr];
        end
    end

    // Mark memory: clearing pass has the write port to itself
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mark_mem[r_clr_addr] <= '0;
        end else if (s1_go && wr) begin
            r_mark_mem[s1_addr] <= '{mark: mark_new, epoch: r_epoch};
        end
        if (in_acc) begin
            r_rd_ent <= r_mark_mem[in_addr];
        end
    end

    // Forwarding for a request to the slot written in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_hit <= 1'b0;
        end else if (in_acc) begin
            r_fw_hit <= s1_go && wr && (s1_addr == in_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_fw_val  <= val_new;
            r_fw_mark <= mark_new;
        end
    end

    // Session state and clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sess     <= 1'b0;
            r_cnt      <= '0;
            r_epoch    <= '0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= ADDR_W'(r_clr_addr + 1'b1);
                if (r_clr_addr == ADDR_W'(SLOT_COUNT - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (s1_go) begin
                r_sess  <= n_sess;
                r_cnt   <= n_cnt;
                r_epoch <= n_epoch;
                if (clr_start) begin
                    r_clearing <= 1'b1;
                    r_clr_addr <= '0;
                end
            end
        end
    end

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_go) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_req <= i_in_req;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_go) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out <= rsp;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_rsp   = r_out;

endmodule

>>> rtl/mvsf_checker.sv
`include "assert_macros.svh"

module mvsf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input mvsf_pkg::t_out_rsp                o_out_rsp
);

    logic out_stall;
    logic rsp_closed;
    logic rsp_cleared;
    logic rsp_marked;
    logic rsp_cnt_ok;

    assign out_stall   = o_out_valid && !i_out_ready;
    assign rsp_closed  = o_out_valid && !o_out_rsp.session_open;
    assign rsp_cleared = (o_out_rsp.candidate_count == '0) && !o_out_rsp.still_candidate &&
                         (o_out_rsp.stored_value == '0);
    assign rsp_marked  = o_out_valid && o_out_rsp.still_candidate;
    assign rsp_cnt_ok  = o_out_rsp.candidate_count <= mvsf_pkg::CNT_MAX;

    // A stalled response holds
    `MVSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_rsp))

    // Closed session reports nothing
    `MVSF_ASSERT_IMP(a_closed_zero, i_clk, i_rst_n, rsp_closed, rsp_cleared)

    // A marked slot is counted
    `MVSF_ASSERT_IMP(a_mark_counted, i_clk, i_rst_n, rsp_marked, o_out_rsp.candidate_count != '0)

    // Count never exceeds the addressable slots
    `MVSF_ASSERT_IMP(a_count_max, i_clk, i_rst_n, o_out_valid, rsp_cnt_ok)

endmodule

bind memory_value_search_filter mvsf_checker u_mvsf_checker (.*);
